[rtl/fbb_pkg.sv]
// Package for the frame buffer blitter: action, status, window and register codes, result type.
// Used by frame_buffer_blitter_unit, the checker and the testbench; no dependencies.
`default_nettype none
package fbb_pkg;
    localparam logic [2:0] ACT_FILL   = 3'd0;
    localparam logic [2:0] ACT_COPY   = 3'd1;
    localparam logic [2:0] ACT_OPEN_W = 3'd2;
    localparam logic [2:0] ACT_WRITE  = 3'd3;
    localparam logic [2:0] ACT_OPEN_R = 3'd4;
    localparam logic [2:0] ACT_READ   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INVAL = 2'd1;
    localparam logic [1:0] ST_NOWIN = 2'd2;

    localparam logic [1:0] WIN_NONE  = 2'd0;
    localparam logic [1:0] WIN_WRITE = 2'd1;
    localparam logic [1:0] WIN_READ  = 2'd2;

    localparam int REG_HRES = 0;
    localparam int REG_VRES = 1;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] pixel_out;
        logic        last_pixel;
    } t_result;
endpackage
`default_nettype wire

[rtl/frame_buffer_blitter_unit.sv]
// Frame buffer blitter top level: one frame store memory with a sequencer; depends on fbb_pkg.
// After reset a clearing pass zeroes every word of the store, taking no request.
// From accept to result valid: a rejected request or an open passes S_OUT; a write pixel
// passes S_ADDR, S_RUN and S_OUT and a read pixel adds S_RDW; fill runs S_ADDR then S_RUN
// per pixel for each row, and copy adds S_WR per pixel (single store port). The next request
// can be taken in the cycle that accepts the result; none is taken while an item is in flight.
`default_nettype none
module frame_buffer_blitter_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 768
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // action[2:0], src_x[12:3], src_y[22:13], dst_x[32:23], dst_y[42:33],
    // rect_width[53:43], rect_height[63:54], pixel_in[95:64]
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // status[1:0], pixel_out[33:2], zero fill above
    output logic [39:0] m_axis_tdata,
    // last_pixel
    output logic        m_axis_tlast,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data
);
    import fbb_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ADDR  = 3'd2;
    localparam logic [2:0] S_RUN   = 3'd3;
    localparam logic [2:0] S_WR    = 3'd4;
    localparam logic [2:0] S_RDW   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;
    logic        mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0] mem_wdata;

    logic [2:0]  r_state;
    logic [10:0] r_hres;
    logic [9:0]  r_vres;
    logic [1:0]  r_wmode;
    logic [9:0]  r_wleft, r_wtop, r_wrows, r_ccol, r_crow;
    logic [10:0] r_wspan;
    logic [AW-1:0] r_clr;

    logic [2:0]  r_act;
    logic [9:0]  r_sx, r_sy, r_dx, r_dy;
    logic [10:0] r_w;
    logic [9:0]  r_h;
    logic [31:0] r_pix;
    logic [10:0] r_c;
    logic [9:0]  r_r;
    logic        r_last;
    logic [AW-1:0] r_saddr, r_daddr;
    t_result     r_res;
    logic        r_ovalid;

    logic [12:0] eff_w, eff_h;
    logic [12:0] pitch;
    logic [2:0]  in_act;
    logic [9:0]  in_sx, in_sy, in_dx, in_dy, in_h;
    logic [10:0] in_w;
    logic [31:0] in_pix;
    logic        dst_ok, src_ok;
    logic [9:0]  wx, wy;
    logic        win_ok;
    logic        pix_ok;
    logic [9:0]  n_sx, n_sy;
    logic        accept;
    logic [9:0]  row_s, row_d;
    logic [12:0] cur_col;
    logic [12:0] nxt_col;

    assign eff_w = (13'(r_hres) > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : 13'(r_hres);
    assign eff_h = (13'(r_vres) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(r_vres);
    assign pitch = eff_w;

    assign in_act = s_axis_tdata[2:0];
    assign in_sx  = s_axis_tdata[12:3];
    assign in_sy  = s_axis_tdata[22:13];
    assign in_dx  = s_axis_tdata[32:23];
    assign in_dy  = s_axis_tdata[42:33];
    assign in_w   = s_axis_tdata[53:43];
    assign in_h   = s_axis_tdata[63:54];
    assign in_pix = s_axis_tdata[95:64];

    assign dst_ok = (in_w != '0) && (in_h != '0) && (13'(in_dx) + 13'(in_w) <= eff_w)
                    && (13'(in_dy) + 13'(in_h) <= eff_h);
    assign src_ok = (in_w != '0) && (in_h != '0) && (13'(in_sx) + 13'(in_w) <= eff_w)
                    && (13'(in_sy) + 13'(in_h) <= eff_h);
    assign wx = (in_act == ACT_OPEN_W) ? in_dx : in_sx;
    assign wy = (in_act == ACT_OPEN_W) ? in_dy : in_sy;
    assign win_ok = (in_act == ACT_OPEN_W) ? dst_ok : src_ok;
    assign pix_ok = (in_act == ACT_WRITE && r_wmode == WIN_WRITE)
                    || (in_act == ACT_READ && r_wmode == WIN_READ);
    assign n_sx = pix_ok ? (r_wleft + r_ccol) : in_sx;
    assign n_sy = pix_ok ? (r_wtop + r_crow) : in_sy;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign o_cfg_ready   = (r_state == S_IDLE) && !r_ovalid && !s_axis_tvalid;
    assign accept = s_axis_tvalid && s_axis_tready;

    // Row of the current copy/fill step; copy runs bottom-up when dst is below src.
    always_comb begin
        if (r_act == ACT_COPY && r_dy > r_sy) begin
            row_s = r_sy + (r_h - 10'd1 - r_r);
            row_d = r_dy + (r_h - 10'd1 - r_r);
        end else begin
            row_s = r_sy + r_r;
            row_d = r_dy + r_r;
        end
    end

    // Within a copy row, go right-to-left when dst is right of src on the same row.
    always_comb begin
        if (r_act == ACT_COPY && r_dx > r_sx && r_dy == r_sy) begin
            cur_col = 13'(r_w) - 13'd1 - 13'(r_c);
        end else begin
            cur_col = 13'(r_c);
        end
    end
    assign nxt_col = 13'(r_c) + 13'd1;

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_daddr + AW'(cur_col);
        mem_wdata = r_pix;
        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr;
                mem_wdata = '0;
            end
            S_RUN: begin
                if (r_act == ACT_FILL) begin
                    mem_we = 1'b1;
                end else if (r_act == ACT_COPY) begin
                    mem_addr = r_saddr + AW'(cur_col);
                end else if (r_act == ACT_WRITE) begin
                    mem_we   = 1'b1;
                    mem_addr = r_daddr;
                end else begin
                    mem_addr = r_daddr;
                end
            end
            S_WR: begin
                mem_we    = 1'b1;
                mem_wdata = r_rdata;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_hres   <= 11'd1024;
            r_vres   <= 10'd768;
            r_wmode  <= WIN_NONE;
            r_wleft  <= '0;
            r_wtop   <= '0;
            r_wspan  <= '0;
            r_wrows  <= '0;
            r_ccol   <= '0;
            r_crow   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == 1'(REG_HRES)) begin
                    r_hres <= i_cfg_data;
                end else begin
                    r_vres <= i_cfg_data[9:0];
                end
                r_wmode <= WIN_NONE;
                r_ccol  <= '0;
                r_crow  <= '0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_act   <= in_act;
                        r_sx    <= n_sx;
                        r_sy    <= n_sy;
                        r_dx    <= in_dx;
                        r_dy    <= in_dy;
                        r_w     <= in_w;
                        r_h     <= in_h;
                        r_pix   <= in_pix;
                        r_c     <= '0;
                        r_r     <= '0;
                        r_res.pixel_out  <= '0;
                        r_res.last_pixel <= 1'b0;
                        priority if (in_act == ACT_FILL) begin
                            r_last       <= 1'b0;
                            r_res.status <= dst_ok ? ST_OK : ST_INVAL;
                            r_state      <= dst_ok ? S_ADDR : S_OUT;
                        end else if (in_act == ACT_COPY) begin
                            r_last       <= 1'b0;
                            r_res.status <= (dst_ok && src_ok) ? ST_OK : ST_INVAL;
                            r_state      <= (dst_ok && src_ok) ? S_ADDR : S_OUT;
                        end else if (in_act == ACT_OPEN_W || in_act == ACT_OPEN_R) begin
                            r_last  <= 1'b0;
                            r_state <= S_OUT;
                            r_ccol  <= '0;
                            r_crow  <= '0;
                            if (win_ok) begin
                                r_res.status <= ST_OK;
                                r_wmode <= (in_act == ACT_OPEN_W) ? WIN_WRITE : WIN_READ;
                                r_wleft <= wx;
                                r_wtop  <= wy;
                                r_wspan <= in_w;
                                r_wrows <= in_h;
                            end else begin
                                r_wmode      <= WIN_NONE;
                                r_res.status <= ST_INVAL;
                            end
                        end else if (in_act == ACT_WRITE || in_act == ACT_READ) begin
                            if (pix_ok) begin
                                r_res.status <= ST_OK;
                                if (11'(r_ccol) + 11'd1 >= r_wspan) begin
                                    r_ccol <= '0;
                                    if (r_crow + 10'd1 >= r_wrows) begin
                                        r_last  <= 1'b1;
                                        r_wmode <= WIN_NONE;
                                        r_crow  <= '0;
                                    end else begin
                                        r_last <= 1'b0;
                                        r_crow <= r_crow + 10'd1;
                                    end
                                end else begin
                                    r_last <= 1'b0;
                                    r_ccol <= r_ccol + 10'd1;
                                end
                                r_state <= S_ADDR;
                            end else begin
                                r_last       <= 1'b0;
                                r_res.status <= ST_NOWIN;
                                r_state      <= S_OUT;
                            end
                        end else begin
                            r_last       <= 1'b0;
                            r_res.status <= ST_INVAL;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_ADDR: begin
                    if (r_act == ACT_WRITE || r_act == ACT_READ) begin
                        r_daddr <= AW'(25'(r_sy) * 25'(pitch) + 25'(r_sx));
                    end else begin
                        r_saddr <= AW'(25'(row_s) * 25'(pitch) + 25'(r_sx));
                        r_daddr <= AW'(25'(row_d) * 25'(pitch) + 25'(r_dx));
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (r_act == ACT_COPY) begin
                        r_state <= S_WR;
                    end else if (r_act == ACT_FILL) begin
                        if (nxt_col >= 13'(r_w)) begin
                            r_c <= '0;
                            if (r_r + 10'd1 >= r_h) begin
                                r_state <= S_OUT;
                            end else begin
                                r_r     <= r_r + 10'd1;
                                r_state <= S_ADDR;
                            end
                        end else begin
                            r_c <= nxt_col[10:0];
                        end
                    end else if (r_act == ACT_WRITE) begin
                        r_res.last_pixel <= r_last;
                        r_state          <= S_OUT;
                    end else begin
                        r_res.last_pixel <= r_last;
                        r_state          <= S_RDW;
                    end
                end
                S_WR: begin
                    if (nxt_col >= 13'(r_w)) begin
                        r_c <= '0;
                        if (r_r + 10'd1 >= r_h) begin
                            r_state <= S_OUT;
                        end else begin
                            r_r     <= r_r + 10'd1;
                            r_state <= S_ADDR;
                        end
                    end else begin
                        r_c     <= nxt_col[10:0];
                        r_state <= S_RUN;
                    end
                end
                S_RDW: begin
                    r_res.pixel_out <= r_rdata;
                    r_state         <= S_OUT;
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_res.pixel_out, r_res.status};
    assign m_axis_tlast  = r_res.last_pixel;

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("request taken while busy");
    a_last_success: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[1:0] == ST_OK))
        else $error("last pixel with failing status");
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_res.last_pixel) |-> (r_wmode == WIN_NONE))
        else $error("window left open after last pixel");
`endif
endmodule
`default_nettype wire

[tb/frame_buffer_blitter_checker.sv]
`timescale 1ns / 100ps
// Checker for the frame buffer blitter: watches the request, result and register
// channels, keeps its own frame store and window state and compares every result.
// Depends on fbb_pkg.
module frame_buffer_blitter_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 768
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_req_valid,
    input  wire         i_req_ready,
    input  wire  [95:0] i_req_data,
    input  wire         i_res_valid,
    input  wire         i_res_ready,
    input  wire  [39:0] i_res_data,
    input  wire         i_res_last,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_ready,
    input  wire  [0:0]  i_cfg_index,
    input  wire  [10:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending
);
    import fbb_pkg::*;

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;

    bit [31:0]  pixels [STORE_SIZE];
    bit [31:0]  row_buf [MAX_WIDTH];
    logic [10:0] hres;
    logic [9:0]  vres;
    logic [1:0]  win_mode;
    int          win_left, win_top, win_span, win_rows, cur_col, cur_row;
    t_result     expected_results [$];

    function automatic int pitch();
        return (hres > MAX_WIDTH) ? MAX_WIDTH : int'(hres);
    endfunction

    function automatic bit rect_fits(int x, int y, int w, int h);
        int lim_h;
        lim_h = (vres > MAX_HEIGHT) ? MAX_HEIGHT : int'(vres);
        if (w == 0 || h == 0) return 0;
        return (x + w <= pitch()) && (y + h <= lim_h);
    endfunction

    function automatic int cursor_address(output logic done);
        int addr;
        addr = (win_top + cur_row) * pitch() + win_left + cur_col;
        done = 1'b0;
        cur_col++;
        if (cur_col >= win_span) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= win_rows) begin
                done = 1'b1;
                win_mode = WIN_NONE;
                cur_col = 0;
                cur_row = 0;
            end
        end
        return (addr < STORE_SIZE) ? addr : 0;
    endfunction

    function automatic t_result blit_outcome(logic [95:0] d);
        t_result res;
        logic [2:0]  act;
        int sx, sy, dx, dy, w, h, p, r, rr, c, x, y;
        logic [31:0] pix;
        logic done;
        act = d[2:0];
        sx = d[12:3];
        sy = d[22:13];
        dx = d[32:23];
        dy = d[42:33];
        w = d[53:43];
        h = d[63:54];
        pix = d[95:64];
        p = pitch();
        res = '0;
        res.status = ST_OK;
        case (act)
            ACT_FILL: begin
                if (!rect_fits(dx, dy, w, h)) begin
                    res.status = ST_INVAL;
                end else begin
                    for (r = 0; r < h; r++)
                        for (c = 0; c < w; c++) pixels[(dy + r) * p + dx + c] = pix;
                end
            end
            ACT_COPY: begin
                if (!rect_fits(dx, dy, w, h) || !rect_fits(sx, sy, w, h)) begin
                    res.status = ST_INVAL;
                end else begin
                    for (r = 0; r < h; r++) begin
                        rr = (dy <= sy) ? r : h - 1 - r;
                        for (c = 0; c < w; c++) row_buf[c] = pixels[(sy + rr) * p + sx + c];
                        for (c = 0; c < w; c++) pixels[(dy + rr) * p + dx + c] = row_buf[c];
                    end
                end
            end
            ACT_OPEN_W, ACT_OPEN_R: begin
                x = (act == ACT_OPEN_W) ? dx : sx;
                y = (act == ACT_OPEN_W) ? dy : sy;
                if (!rect_fits(x, y, w, h)) begin
                    res.status = ST_INVAL;
                    win_mode = WIN_NONE;
                    cur_col = 0;
                    cur_row = 0;
                end else begin
                    win_mode = (act == ACT_OPEN_W) ? WIN_WRITE : WIN_READ;
                    win_left = x;
                    win_top = y;
                    win_span = w;
                    win_rows = h;
                    cur_col = 0;
                    cur_row = 0;
                end
            end
            ACT_WRITE: begin
                if (win_mode != WIN_WRITE) begin
                    res.status = ST_NOWIN;
                end else begin
                    pixels[cursor_address(done)] = pix;
                    res.last_pixel = done;
                end
            end
            ACT_READ: begin
                if (win_mode != WIN_READ) begin
                    res.status = ST_NOWIN;
                end else begin
                    res.pixel_out = pixels[cursor_address(done)];
                    res.last_pixel = done;
                end
            end
            default: res.status = ST_INVAL;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            hres = 11'd1024;
            vres = 10'd768;
            win_mode = WIN_NONE;
            win_left = 0;
            win_top = 0;
            win_span = 0;
            win_rows = 0;
            cur_col = 0;
            cur_row = 0;
            o_errors <= 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_HRES) hres = i_cfg_data;
                else vres = i_cfg_data[9:0];
                win_mode = WIN_NONE;
                cur_col = 0;
                cur_row = 0;
            end
            if (i_req_valid && i_req_ready) expected_results.push_back(blit_outcome(i_req_data));
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result status=%0d pixel=%h last=%0b", $time,
                             i_res_data[1:0], i_res_data[33:2], i_res_last);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (want.status !== i_res_data[1:0] || want.pixel_out !== i_res_data[33:2]
                            || want.last_pixel !== i_res_last || i_res_data[39:34] !== '0) begin
                        $display("%0t: expected status=%0d pixel=%h last=%0b, got %0d %h %0b",
                                 $time, want.status, want.pixel_out, want.last_pixel,
                                 i_res_data[1:0], i_res_data[33:2], i_res_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end
endmodule

[tb/frame_buffer_blitter_unit_tb.sv]
`timescale 1ns / 100ps
// Top of the frame buffer blitter testbench: clock, reset, directed and random
// requests, register writes and the verdict. Depends on fbb_pkg and the checker.
module frame_buffer_blitter_unit_tb;
    import fbb_pkg::*;

    localparam int IDLE_LIMIT = 4000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [95:0] s_axis_tdata = '0;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;
    wire         m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    wire         o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [10:0] i_cfg_data = '0;
    int          errors, pending, idle_cycles, req_count;
    int          scr_w = 1024, scr_h = 768;

    frame_buffer_blitter_unit dut (.*);

    frame_buffer_blitter_checker chk (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready), .i_req_data(s_axis_tdata),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready), .i_res_data(m_axis_tdata),
        .i_res_last(m_axis_tlast),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    initial begin
        int run, stall;
        @(posedge i_clk);
        forever begin
            run = $urandom_range(1, 40);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge i_clk);
            stall = gap_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
        end
    end

    task automatic send_request(logic [2:0] act, int sx, int sy, int dx, int dy, int w,
                                int h, logic [31:0] pix);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {pix, h[9:0], w[10:0], dy[9:0], dx[9:0], sy[9:0], sx[9:0], act};
        do @(posedge i_clk); while (!s_axis_tready);
        req_count++;
    endtask

    task automatic send_noise();
        logic [95:0] d;
        d = {$urandom, $urandom, $urandom};
        if (d[2:1] == 2'b00) d[2:0] = $urandom_range(0, 1) ? ACT_OPEN_W : ACT_OPEN_R;
        send_request(d[2:0], d[12:3], d[22:13], d[32:23], d[42:33], d[53:43], d[63:54],
                     d[95:64]);
    endtask

    task automatic write_register(logic [0:0] idx, logic [10:0] val);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_HRES) scr_w = (val > 1024) ? 1024 : val;
        else scr_h = (val[9:0] > 768) ? 768 : val[9:0];
    endtask

    function automatic int corner(int scr, int sz);
        if (scr < sz) return $urandom_range(0, 3);
        return $urandom_range(0, (scr - sz > 60) ? 60 : scr - sz);
    endfunction

    task automatic window_burst(bit rd);
        int w, h, x, y, n;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 4);
        x = corner(scr_w, w);
        y = corner(scr_h, h);
        send_request(rd ? ACT_OPEN_R : ACT_OPEN_W, x, y, x, y, w, h, $urandom);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, w * h) : w * h;
        repeat (n) send_request(rd ? ACT_READ : ACT_WRITE, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
    endtask

    task automatic rect_op();
        int w, h, sx, sy, dx, dy;
        w = $urandom_range(0, 10);
        h = $urandom_range(0, 8);
        sx = corner(scr_w, w);
        sy = corner(scr_h, h);
        dx = corner(scr_w, w);
        dy = corner(scr_h, h);
        send_request($urandom_range(0, 1) ? ACT_COPY : ACT_FILL, sx, sy, dx, dy, w, h, $urandom);
    endtask

    initial begin
        logic [10:0] hset [6];
        logic [10:0] vset [6];
        int phase, roll;
        hset = '{11'd1024, 11'd2047, 11'd1, 11'd0, 11'd640, 11'd100};
        vset = '{11'd768, 11'd1023, 11'd1, 11'd768, 11'd0, 11'd60};
        req_count = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_request(ACT_FILL, 0, 0, 0, 0, 1024, 768, 32'hFFFF_FFFF);
        send_request(ACT_FILL, 0, 0, 1023, 767, 1, 1, 32'h1234_5678);
        send_request(ACT_FILL, 0, 0, 5, 5, 0, 3, 32'h0);
        send_request(ACT_FILL, 0, 0, 5, 5, 3, 0, 32'h0);
        send_request(ACT_FILL, 0, 0, 1000, 0, 25, 1, 32'h0);
        send_request(ACT_FILL, 0, 0, 1, 1, 3, 2, 32'hA5A5_5A5A);
        send_request(ACT_COPY, 0, 0, 2, 1, 8, 4, 32'h0);
        send_request(ACT_COPY, 2, 1, 0, 0, 8, 4, 32'h0);
        send_request(ACT_COPY, 1020, 0, 0, 0, 8, 4, 32'h0);
        send_request(ACT_OPEN_W, 0, 0, 1022, 766, 2, 2, 32'h0);
        send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'h0000_0001);
        send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
        send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'h0);
        send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'hDEAD_BEEF);
        send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'h1);
        send_request(ACT_OPEN_R, 1022, 766, 0, 0, 2, 2, 32'h0);
        send_request(ACT_FILL, 0, 0, 0, 0, 2, 2, 32'h7);
        repeat (4) send_request(ACT_READ, 0, 0, 0, 0, 0, 0, 32'h0);
        send_request(ACT_READ, 0, 0, 0, 0, 0, 0, 32'h0);
        send_request(3'd6, 0, 0, 0, 0, 1, 1, 32'h0);
        send_request(3'd7, 1023, 767, 1023, 767, 2047, 1023, 32'hFFFF_FFFF);
        send_request(ACT_OPEN_W, 0, 0, 1023, 767, 2, 1, 32'h0);

        for (phase = 0; phase < 6; phase++) begin
            write_register(REG_HRES, (phase == 5) ? 11'($urandom_range(1, 2047)) : hset[phase]);
            write_register(REG_VRES, (phase == 5) ? 11'($urandom_range(1, 1023)) : vset[phase]);
            if (phase == 2) send_request(ACT_WRITE, 0, 0, 0, 0, 0, 0, 32'h0);
            while (req_count < 22 + (phase + 1) * 315) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) window_burst(1'b0);
                else if (roll < 70) window_burst(1'b1);
                else if (roll < 88) rect_op();
                else send_noise();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[filelist.f]
rtl/fbb_pkg.sv
rtl/frame_buffer_blitter_unit.sv
tb/frame_buffer_blitter_checker.sv
tb/frame_buffer_blitter_unit_tb.sv
